@@ rtl/nrmc_pkg.sv @@
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam int POSITION_CHARS = 12;
  localparam int STAMP_CHARS    = 8;
  localparam int STAMP_BITS     = STAMP_CHARS * 8;
  localparam int REPORT_BITS    = 128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  localparam logic [2:0] HDR_LEN = 3'd6;

  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LONG   = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_DATE   = 4'd9;

  typedef enum logic [2:0] {
    KIND_TIME      = 3'd0,
    KIND_DATE      = 3'd1,
    KIND_LAT       = 3'd2,
    KIND_LONG      = 3'd3,
    KIND_LAST_LAT  = 3'd4,
    KIND_LAST_LONG = 3'd5
  } item_kind_e;

  typedef struct packed {
    logic [STAMP_BITS-1:0] text;
    logic [3:0]            pos;
  } stamp_res_t;

  function automatic logic [3:0] sat15(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = CH_DOLLAR;
      3'd1: c = CH_G;
      3'd2: c = CH_P;
      3'd3: c = CH_R;
      3'd4: c = CH_M;
      3'd5: c = CH_C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // hh:mm:ss / dd-mm-yy, separator inserted after two and five characters
  function automatic stamp_res_t stamp_char(input logic [STAMP_BITS-1:0] t,
                                            input logic [3:0] p,
                                            input logic [7:0] c,
                                            input logic [7:0] sep);
    stamp_res_t r;
    logic [3:0] n;
    r.text = t;
    if (p < 4'd8) begin
      r.text[{p[2:0], 3'b000} +: 8] = c;
    end
    n = sat15(p);
    if (n == 4'd2 || n == 4'd5) begin
      r.text[{n[2:0], 3'b000} +: 8] = sep;
      n = sat15(n);
    end
    r.pos = n;
    return r;
  endfunction

endpackage

@@ rtl/nrmc_in_if.sv @@
`timescale 1ns / 1ps

interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

@@ rtl/nrmc_out_if.sv @@
`timescale 1ns / 1ps

interface nrmc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [63:0] text_low;
  logic [31:0] text_high;
  logic        fix_valid;
  logic        sentence_found;
  logic        last_item;

  modport source (output valid, output item_kind, output text_low, output text_high,
                  output fix_valid, output sentence_found, output last_item,
                  input ready);
  modport sink   (input valid, input item_kind, input text_low, input text_high,
                  input fix_valid, input sentence_found, input last_item,
                  output ready);
endinterface

@@ rtl/nmea_rmc_field_parser.sv @@
`timescale 1ns / 1ps

// Timing: each byte is parsed on transfer; a burst-end byte puts the first of six
// report items on the output in the next cycle, one item per cycle while the sink is ready.
// Throughput: one byte per cycle; after a burst-end byte, input waits until the sixth report
// item transfers (input is taken again in that same cycle).
// Reset: asynchronous active low; clears parser state and all text stores to zero (report snapshot is not reset).
module nmea_rmc_field_parser #(
  parameter int POSITION_CHARS = nrmc_pkg::POSITION_CHARS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nrmc_in_if.sink    rx_i,
  nrmc_out_if.source rpt_o
);

  localparam int PosBits = POSITION_CHARS * 8;
  localparam int StBits  = nrmc_pkg::STAMP_BITS;

  logic [2:0]         hdr_q,   hdr_d;
  logic               insent_q, insent_d;
  logic [3:0]         field_q, field_d;
  logic [3:0]         pos_q,   pos_d;
  logic               fix_q,   fix_d;
  logic [StBits-1:0]  time_q,  time_d;
  logic [StBits-1:0]  date_q,  date_d;
  logic [PosBits-1:0] lat_q,   lat_d;
  logic [PosBits-1:0] long_q,  long_d;
  logic [PosBits-1:0] llat_q,  llat_d;
  logic [PosBits-1:0] llong_q, llong_d;

  logic                 busy_q, busy_d;
  nrmc_pkg::item_kind_e idx_q, idx_d;
  logic [63:0]          rpt_low_q  [6];
  logic [31:0]          rpt_high_q [4];
  logic                 rpt_fix_q, rpt_found_q;

  logic in_fire, out_fire, out_done;
  logic found_d;

  assign out_fire = busy_q && rpt_o.ready;
  assign out_done = out_fire && (idx_q == nrmc_pkg::KIND_LAST_LONG);
  assign rx_i.ready = !busy_q || out_done;
  assign in_fire = rx_i.valid && rx_i.ready;

  // byte parser and burst commit
  always_comb begin
    logic [7:0]           c;
    logic [3:0]           np;
    nrmc_pkg::stamp_res_t sr;
    logic                 commit;
    c       = rx_i.rx_byte;
    np      = 4'd0;
    sr      = '0;
    commit  = 1'b0;
    hdr_d   = hdr_q;
    insent_d = insent_q;
    field_d = field_q;
    pos_d   = pos_q;
    fix_d   = fix_q;
    time_d  = time_q;
    date_d  = date_q;
    lat_d   = lat_q;
    long_d  = long_q;
    llat_d  = llat_q;
    llong_d = llong_q;
    if (in_fire) begin
      if (!insent_q) begin
        if (c == nrmc_pkg::CH_DOLLAR) begin
          hdr_d = 3'd1;
        end else if (hdr_q != 3'd0 && hdr_q < nrmc_pkg::HDR_LEN &&
                     c == nrmc_pkg::hdr_char(hdr_q)) begin
          if (hdr_q == nrmc_pkg::HDR_LEN - 3'd1) begin
            insent_d = 1'b1;
            field_d  = 4'd0;
            pos_d    = 4'd0;
            hdr_d    = 3'd0;
          end else begin
            hdr_d = hdr_q + 3'd1;
          end
        end else begin
          hdr_d = 3'd0;
        end
      end else if (c == nrmc_pkg::CH_COMMA) begin
        field_d = nrmc_pkg::sat15(field_q);
        pos_d   = 4'd0;
      end else begin
        np = nrmc_pkg::sat15(pos_q);
        case (field_q)
          nrmc_pkg::FLD_TIME: begin
            sr     = nrmc_pkg::stamp_char(time_q, pos_q, c, nrmc_pkg::CH_COLON);
            time_d = sr.text;
            pos_d  = sr.pos;
          end
          nrmc_pkg::FLD_DATE: begin
            sr     = nrmc_pkg::stamp_char(date_q, pos_q, c, nrmc_pkg::CH_DASH);
            date_d = sr.text;
            pos_d  = sr.pos;
          end
          nrmc_pkg::FLD_STATUS: fix_d = (c == nrmc_pkg::CH_A);
          nrmc_pkg::FLD_LAT: begin
            if (np != pos_q && int'(np) < POSITION_CHARS) begin
              lat_d[{np, 3'b000} +: 8] = c;
            end
            pos_d = np;
          end
          nrmc_pkg::FLD_LONG: begin
            if (np != pos_q && int'(np) < POSITION_CHARS) begin
              long_d[{np, 3'b000} +: 8] = c;
            end
            pos_d = np;
          end
          nrmc_pkg::FLD_NS: begin
            if (c == nrmc_pkg::CH_N || c == nrmc_pkg::CH_S) begin
              lat_d[7:0] = c;
            end
          end
          nrmc_pkg::FLD_EW: begin
            if (c == nrmc_pkg::CH_E || c == nrmc_pkg::CH_W) begin
              long_d[7:0] = c;
            end
          end
          default: ;
        endcase
      end
      commit = rx_i.burst_end;
    end
    found_d = insent_d;
    if (commit) begin
      if (insent_d && fix_d) begin
        llat_d  = lat_d;
        llong_d = long_d;
      end
      hdr_d    = 3'd0;
      insent_d = 1'b0;
      field_d  = 4'd0;
      pos_d    = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= 3'd0;
      insent_q <= 1'b0;
      field_q  <= 4'd0;
      pos_q    <= 4'd0;
      fix_q    <= 1'b0;
      time_q   <= '0;
      date_q   <= '0;
      lat_q    <= '0;
      long_q   <= '0;
      llat_q   <= '0;
      llong_q  <= '0;
    end else begin
      hdr_q    <= hdr_d;
      insent_q <= insent_d;
      field_q  <= field_d;
      pos_q    <= pos_d;
      fix_q    <= fix_d;
      time_q   <= time_d;
      date_q   <= date_d;
      lat_q    <= lat_d;
      long_q   <= long_d;
      llat_q   <= llat_d;
      llong_q  <= llong_d;
    end
  end

  // report control
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (out_fire) begin
      if (out_done) begin
        busy_d = 1'b0;
      end else begin
        idx_d = nrmc_pkg::item_kind_e'(idx_q + 3'd1);
      end
    end
    if (in_fire && rx_i.burst_end) begin
      busy_d = 1'b1;
      idx_d  = nrmc_pkg::KIND_TIME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= nrmc_pkg::KIND_TIME;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // report snapshot; positions past the store read as zero
  logic [nrmc_pkg::REPORT_BITS-1:0] lat_x, long_x, llat_x, llong_x;
  assign lat_x   = nrmc_pkg::REPORT_BITS'(lat_d);
  assign long_x  = nrmc_pkg::REPORT_BITS'(long_d);
  assign llat_x  = nrmc_pkg::REPORT_BITS'(llat_d);
  assign llong_x = nrmc_pkg::REPORT_BITS'(llong_d);

  always_ff @(posedge clk_i) begin
    if (in_fire && rx_i.burst_end) begin
      rpt_low_q[0]  <= time_d;
      rpt_low_q[1]  <= date_d;
      rpt_low_q[2]  <= lat_x[63:0];
      rpt_low_q[3]  <= long_x[63:0];
      rpt_low_q[4]  <= llat_x[63:0];
      rpt_low_q[5]  <= llong_x[63:0];
      rpt_high_q[0] <= lat_x[95:64];
      rpt_high_q[1] <= long_x[95:64];
      rpt_high_q[2] <= llat_x[95:64];
      rpt_high_q[3] <= llong_x[95:64];
      rpt_fix_q     <= fix_d;
      rpt_found_q   <= found_d;
    end
  end

  always_comb begin
    rpt_o.text_low  = rpt_low_q[0];
    rpt_o.text_high = 32'd0;
    case (idx_q)
      nrmc_pkg::KIND_TIME:      rpt_o.text_low = rpt_low_q[0];
      nrmc_pkg::KIND_DATE:      rpt_o.text_low = rpt_low_q[1];
      nrmc_pkg::KIND_LAT: begin
        rpt_o.text_low  = rpt_low_q[2];
        rpt_o.text_high = rpt_high_q[0];
      end
      nrmc_pkg::KIND_LONG: begin
        rpt_o.text_low  = rpt_low_q[3];
        rpt_o.text_high = rpt_high_q[1];
      end
      nrmc_pkg::KIND_LAST_LAT: begin
        rpt_o.text_low  = rpt_low_q[4];
        rpt_o.text_high = rpt_high_q[2];
      end
      nrmc_pkg::KIND_LAST_LONG: begin
        rpt_o.text_low  = rpt_low_q[5];
        rpt_o.text_high = rpt_high_q[3];
      end
      default: ;
    endcase
  end

  assign rpt_o.valid          = busy_q;
  assign rpt_o.item_kind      = idx_q;
  assign rpt_o.fix_valid      = rpt_fix_q;
  assign rpt_o.sentence_found = rpt_found_q;
  assign rpt_o.last_item      = (idx_q == nrmc_pkg::KIND_LAST_LONG);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import nrmc_pkg::*;

  localparam int POS = POSITION_CHARS;
  localparam int DIR_ROWS = 4;

  localparam logic [47:0] RMC_HDR = {CH_C, CH_M, CH_R, CH_P, CH_G, CH_DOLLAR};
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_V    = 8'h56;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_BLANK,
    CHK_FIX
  } dir_chk_e;

  typedef struct packed {
    logic [143:0] txt;
    logic [7:0]   n;
    logic [7:0]   last_byte;
    logic         fin;
    dir_chk_e     chk;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] lo;
    logic [31:0] hi;
    logic        fix;
    logic        found;
    logic        last;
  } rmc_report_t;

  logic clk_i;
  logic rst_ni;

  nrmc_in_if  rx_bus ();
  nrmc_out_if rpt_bus ();

  nmea_rmc_field_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .rpt_o  (rpt_bus)
  );

  // parser state as the block should hold it
  logic [2:0]       hunt_cnt;
  logic             in_rmc;
  logic [3:0]       field_no;
  logic [3:0]       char_no;
  logic             fix_seen;
  logic [63:0]      time_txt;
  logic [63:0]      date_txt;
  logic [8*POS-1:0] lat_txt;
  logic [8*POS-1:0] lon_txt;
  logic [8*POS-1:0] last_lat_txt;
  logic [8*POS-1:0] last_lon_txt;

  rmc_report_t reports_due[$];
  dir_chk_e    chk_tags[$];
  logic [7:0]  burst_bytes[$];
  dir_row_t    dir_tab[DIR_ROWS];

  int errors;
  bit calm;
  bit hold_req;
  int hold_left;

  function automatic logic [3:0] bump4(input logic [3:0] v);
    return (v == 4'hF) ? v : v + 4'd1;
  endfunction

  function automatic logic [63:0] stamp_put(input logic [63:0] t, input logic [7:0] c,
                                            input logic [7:0] sep);
    logic [63:0] r;
    logic [3:0]  p;
    r = t;
    p = char_no;
    if (p < 4'd8) r[p * 8 +: 8] = c;
    p = bump4(p);
    if (p == 4'd2 || p == 4'd5) begin
      r[p * 8 +: 8] = sep;
      p = bump4(p);
    end
    char_no = p;
    return r;
  endfunction

  function automatic logic [8*POS-1:0] place_char(input logic [8*POS-1:0] t,
                                                  input logic [7:0] c);
    logic [8*POS-1:0] r;
    logic [3:0]       p;
    r = t;
    p = bump4(char_no);
    if (p != char_no && p < POS) r[p * 8 +: 8] = c;
    char_no = p;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] c);
    if (!in_rmc) begin
      if (c == CH_DOLLAR) begin
        hunt_cnt = 3'd1;
      end else if (hunt_cnt != 3'd0 && hunt_cnt < HDR_LEN && c == RMC_HDR[hunt_cnt * 8 +: 8]) begin
        hunt_cnt = hunt_cnt + 3'd1;
        if (hunt_cnt == HDR_LEN) begin
          in_rmc   = 1'b1;
          field_no = 4'd0;
          char_no  = 4'd0;
          hunt_cnt = 3'd0;
        end
      end else begin
        hunt_cnt = 3'd0;
      end
    end else if (c == CH_COMMA) begin
      field_no = bump4(field_no);
      char_no  = 4'd0;
    end else begin
      case (field_no)
        FLD_TIME:   time_txt = stamp_put(time_txt, c, CH_COLON);
        FLD_STATUS: fix_seen = (c == CH_A);
        FLD_LAT:    lat_txt = place_char(lat_txt, c);
        FLD_NS:     if (c == CH_N || c == CH_S) lat_txt[7:0] = c;
        FLD_LONG:   lon_txt = place_char(lon_txt, c);
        FLD_EW:     if (c == CH_E || c == CH_W) lon_txt[7:0] = c;
        FLD_DATE:   date_txt = stamp_put(date_txt, c, CH_DASH);
        default: ;
      endcase
    end
  endtask

  // directed rows whose report is known by inspection
  function automatic rmc_report_t typed_report(input dir_chk_e chk, input int k);
    rmc_report_t r;
    r.kind  = 3'(k);
    r.lo    = '0;
    r.hi    = '0;
    r.fix   = (chk == CHK_FIX);
    r.found = (chk == CHK_FIX);
    r.last  = (k == KIND_LAST_LONG);
    if (chk == CHK_FIX) begin
      case (item_kind_e'(k))
        KIND_TIME:                r.lo = 64'h31;    // "1"
        KIND_LAT, KIND_LAST_LAT:  r.lo = 64'h3253;  // "S2"
        KIND_LONG, KIND_LAST_LONG: r.lo = 64'h3357; // "W3"
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic post_report(input dir_chk_e chk);
    rmc_report_t  r;
    logic [127:0] src;
    logic         found;
    found = in_rmc;
    if (in_rmc && fix_seen) begin
      last_lat_txt = lat_txt;
      last_lon_txt = lon_txt;
    end
    for (int k = KIND_TIME; k <= KIND_LAST_LONG; k++) begin
      case (item_kind_e'(k))
        KIND_TIME:     src = 128'(time_txt);
        KIND_DATE:     src = 128'(date_txt);
        KIND_LAT:      src = 128'(lat_txt);
        KIND_LONG:     src = 128'(lon_txt);
        KIND_LAST_LAT: src = 128'(last_lat_txt);
        default:       src = 128'(last_lon_txt);
      endcase
      r.kind  = 3'(k);
      r.lo    = src[63:0];
      r.hi    = src[95:64];
      r.fix   = fix_seen;
      r.found = found;
      r.last  = (k == KIND_LAST_LONG);
      reports_due.push_back((chk == CHK_MODEL) ? r : typed_report(chk, k));
    end
    hunt_cnt = 3'd0;
    in_rmc   = 1'b0;
    field_no = 4'd0;
    char_no  = 4'd0;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    hunt_cnt     = '0;
    in_rmc       = 1'b0;
    field_no     = '0;
    char_no      = '0;
    fix_seen     = 1'b0;
    time_txt     = '0;
    date_txt     = '0;
    lat_txt      = '0;
    lon_txt      = '0;
    last_lat_txt = '0;
    last_lon_txt = '0;
    errors       = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
  end

  // result transfers are checked before the same edge's input transfer is predicted
  always @(posedge clk_i) begin : monitor
    rmc_report_t want;
    dir_chk_e    tag;
    if (rst_ni) begin
      if (rpt_bus.valid && rpt_bus.ready) begin
        if (reports_due.size() == 0) begin
          $error("report transfer with nothing expected");
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("item_kind", 64'(want.kind), 64'(rpt_bus.item_kind));
          check_field("text_low", want.lo, rpt_bus.text_low);
          check_field("text_high", 64'(want.hi), 64'(rpt_bus.text_high));
          check_field("fix_valid", 64'(want.fix), 64'(rpt_bus.fix_valid));
          check_field("sentence_found", 64'(want.found), 64'(rpt_bus.sentence_found));
          check_field("last_item", 64'(want.last), 64'(rpt_bus.last_item));
        end
      end
      if (rx_bus.valid && rx_bus.ready) begin
        tag = chk_tags.pop_front();
        parse_byte(rx_bus.rx_byte);
        if (rx_bus.burst_end) post_report(tag);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      rpt_bus.ready <= 1'b0;
    end else begin
      rpt_bus.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input dir_chk_e chk);
    chk_tags.push_back(chk);
    while (!calm && $urandom_range(99) < 12) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_bus.valid     <= 1'b1;
    rx_bus.rx_byte   <= b;
    rx_bus.burst_end <= fin;
    do @(posedge clk_i); while (!rx_bus.ready);
  endtask

  function automatic logic [7:0] field_char();
    if ($urandom_range(99) < 10) return 8'($urandom_range(255));
    if ($urandom_range(9) == 0) return CH_DOT;
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // mostly well-formed sentences; some noise, bad headers and truncated bursts
  task automatic build_burst();
    int roll;
    int nf;
    int len;
    int cut;
    burst_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 8)) burst_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 2)) burst_bytes.push_back(field_char());
    for (int i = 0; i < HDR_LEN; i++) burst_bytes.push_back(RMC_HDR[i * 8 +: 8]);
    if (roll < 20)
      burst_bytes[burst_bytes.size() - 1 - $urandom_range(4)] = 8'($urandom_range(255));
    nf = ($urandom_range(99) < 15) ? $urandom_range(13, 20) : $urandom_range(0, 12);
    for (int f = 1; f <= nf; f++) begin
      burst_bytes.push_back(CH_COMMA);
      len = ($urandom_range(99) < 12) ? $urandom_range(7, 17) : $urandom_range(0, 5);
      case (f)
        FLD_STATUS: begin
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(2))
              0:       burst_bytes.push_back(CH_A);
              1:       burst_bytes.push_back(CH_V);
              default: burst_bytes.push_back(field_char());
            endcase
          end
        end
        FLD_NS, FLD_EW: begin
          case ($urandom_range(3))
            0:       burst_bytes.push_back((f == FLD_NS) ? CH_N : CH_E);
            1:       burst_bytes.push_back((f == FLD_NS) ? CH_S : CH_W);
            2:       burst_bytes.push_back(field_char());
            default: ;
          endcase
        end
        default: repeat (len) burst_bytes.push_back(field_char());
      endcase
    end
    if ($urandom_range(1)) begin
      burst_bytes.push_back(CH_STAR);
      repeat (2) burst_bytes.push_back(field_char());
    end
    if (roll >= 20 && roll < 28) begin
      cut = $urandom_range(1, burst_bytes.size());
      while (burst_bytes.size() > cut) void'(burst_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    int burst_cnt;
    int byte_cnt;
    rst_ni           = 1'b0;
    rx_bus.valid     = 1'b0;
    rx_bus.rx_byte   = 8'h00;
    rx_bus.burst_end = 1'b0;
    rpt_bus.ready    = 1'b0;
    dir_tab = '{
      '{144'd0,                 8'd0,  8'hFF, 1'b1, CHK_BLANK},
      '{144'd0,                 8'd0,  8'h00, 1'b0, CHK_MODEL},
      '{"$GPRMC,1,A,2,S,3,",   8'd17, CH_W,  1'b1, CHK_FIX},
      '{"$$GPRMC,,V",          8'd10, 8'h80, 1'b1, CHK_MODEL}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < dir_tab[r].n; i++)
        send_byte(dir_tab[r].txt[(dir_tab[r].n - 1 - i) * 8 +: 8], 1'b0, CHK_MODEL);
      send_byte(dir_tab[r].last_byte, dir_tab[r].fin, dir_tab[r].chk);
    end

    burst_cnt = 0;
    byte_cnt  = 0;
    while (byte_cnt < 480 || burst_cnt < 12) begin
      if (burst_cnt == 1) hold_req = 1'b1;
      calm = (burst_cnt >= 5 && burst_cnt < 8);
      build_burst();
      for (int i = 0; i < burst_bytes.size(); i++)
        send_byte(burst_bytes[i], i == burst_bytes.size() - 1, CHK_MODEL);
      byte_cnt += burst_bytes.size();
      burst_cnt++;
    end
    calm = 1'b0;
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("** nmea_rmc_field_parser: PASSED **");
    end else begin
      $display("** nmea_rmc_field_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("** nmea_rmc_field_parser: FAILED **");
    $finish;
  end

endmodule
